[hw/rtl/tzpc_pkg.sv]
// shared types and constants for the two-zone people counter
package tzpc_pkg;

  localparam int DIST_W  = 16;
  localparam int COUNT_W = 16;
  localparam int FILL_W  = 3;
  localparam int PAT_W   = 2;

  // reset value of the occupancy threshold
  localparam logic [DIST_W-1:0] THRESH_RESET = 16'd1000;

  // path fill marks
  localparam logic [FILL_W-1:0] FILL_START = 3'd1;
  localparam logic [FILL_W-1:0] FILL_FULL  = 3'd4;

  // occupancy patterns, bit 0 left, bit 1 right
  localparam logic [PAT_W-1:0] PAT_LEFT  = 2'd1;
  localparam logic [PAT_W-1:0] PAT_RIGHT = 2'd2;
  localparam logic [PAT_W-1:0] PAT_BOTH  = 2'd3;

  // count limits
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = -16'sh8000;

  // one reading held in the input register
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              zone;
  } reading_t;

  // one result on its way to the output register
  typedef struct packed {
    logic                      right_occupied;
    logic                      left_occupied;
    logic                      zone_changed;
    logic signed [COUNT_W-1:0] people_count;
  } result_t;

endpackage

[hw/rtl/tzpc_in_stage.sv]
// input register with slave-side stream handshake
module tzpc_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  tzpc_pkg::reading_t s_item,
  input  logic              advance,
  output logic              held_valid,
  output tzpc_pkg::reading_t held_item
);
  import tzpc_pkg::*;

  // room when empty or when the held reading moves on this cycle
  assign s_tready = !held_valid || advance;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tready) begin
      held_valid <= s_tvalid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      held_item <= s_item;
    end
  end

endmodule

[hw/rtl/tzpc_core.sv]
// occupancy tracking, path record and saturating count
module tzpc_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  tzpc_pkg::reading_t          item,
  input  logic [tzpc_pkg::DIST_W-1:0] threshold,
  output tzpc_pkg::result_t           result
);
  import tzpc_pkg::*;

  logic                      left_state;
  logic                      right_state;
  logic [FILL_W-1:0]         path_fill;
  logic [PAT_W-1:0]          path_record [1:3];
  logic signed [COUNT_W-1:0] net_count;

  logic                      left_next;
  logic                      right_next;
  logic [FILL_W-1:0]         path_fill_next;
  logic [FILL_W-1:0]         fill_inc;
  logic signed [COUNT_W-1:0] net_count_next;
  logic                      occ;
  logic                      changed;
  logic [PAT_W-1:0]          pattern;
  logic [1:0]                rec_idx;
  logic                      rec_we;
  logic                      path_in;
  logic                      path_out;

  // occupancy of this reading and its zone update
  always_comb begin
    occ        = (item.distance < threshold);
    left_next  = left_state;
    right_next = right_state;
    if (item.zone) begin
      right_next = occ;
    end else begin
      left_next = occ;
    end
    changed = item.zone ? (occ != right_state) : (occ != left_state);
    pattern = {right_next, left_next};
  end

  // path judgement on a change event
  always_comb begin
    fill_inc       = (path_fill < FILL_FULL) ? path_fill + FILL_W'(1) : FILL_FULL;
    path_fill_next = path_fill;
    net_count_next = net_count;
    rec_we         = 1'b0;
    rec_idx        = 2'(fill_inc - FILL_W'(1));
    path_in  = (path_record[1] == PAT_LEFT) && (path_record[2] == PAT_BOTH) &&
               (path_record[3] == PAT_RIGHT);
    path_out = (path_record[1] == PAT_RIGHT) && (path_record[2] == PAT_BOTH) &&
               (path_record[3] == PAT_LEFT);
    if (changed) begin
      if (!left_next && !right_next) begin
        if (fill_inc == FILL_FULL) begin
          if (path_in) begin
            if (net_count != COUNT_MAX) begin
              net_count_next = net_count + COUNT_W'(1);
            end
          end else if (path_out) begin
            if (net_count != COUNT_MIN) begin
              net_count_next = net_count - COUNT_W'(1);
            end
          end
        end
        path_fill_next = FILL_START;
      end else begin
        path_fill_next = fill_inc;
        rec_we         = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      left_state  <= 1'b0;
      right_state <= 1'b0;
      path_fill   <= FILL_START;
      net_count   <= '0;
    end else if (step) begin
      left_state  <= left_next;
      right_state <= right_next;
      path_fill   <= path_fill_next;
      net_count   <= net_count_next;
    end
  end

  // path record, entry 0 is always zero and not stored
  always_ff @(posedge clk) begin
    if (rst) begin
      path_record[1] <= '0;
      path_record[2] <= '0;
      path_record[3] <= '0;
    end else if (step && rec_we && (rec_idx != 2'd0)) begin
      path_record[rec_idx] <= pattern;
    end
  end

  // result after this reading
  always_comb begin
    result.people_count   = net_count_next;
    result.zone_changed   = changed;
    result.left_occupied  = left_next;
    result.right_occupied = right_next;
  end

endmodule

[hw/rtl/two_zone_people_counter.sv]
// two-zone doorway people counter, top level
// a reading passes the input register, then the result register, before its result is offered
// throughput: one reading per cycle while the output is not stalled, the state update is a single compare and add
// reset: synchronous, clears occupancy, path record and count, threshold back to 1000
module two_zone_people_counter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [tzpc_pkg::DIST_W-1:0] cfg_wdata,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [15:0]                s_tdata,   // distance[15:0]
  input  logic                       s_tuser,   // zone
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [23:0]                m_tdata    // people_count, zone_changed,
                                                // left_occupied, right_occupied, zero fill
);
  import tzpc_pkg::*;

  logic [DIST_W-1:0] threshold;
  reading_t          s_item;
  reading_t          held_item;
  logic              held_valid;
  logic              advance;
  result_t           result;
  result_t           out_result;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  assign s_item.distance = s_tdata[DIST_W-1:0];
  assign s_item.zone     = s_tuser;

  // a held reading moves when the result register is free or drains
  assign advance = held_valid && (!m_tvalid || m_tready);

  tzpc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_item     (s_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  tzpc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (held_item),
    .threshold (threshold),
    .result    (result)
  );

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_tdata = {5'b0, out_result.right_occupied, out_result.left_occupied,
                    out_result.zone_changed, out_result.people_count};

endmodule

[verif/tzpc_checker.sv]
// checker for the people counter: predicts each result and compares it on the output channel
`timescale 1ns / 1ps

module tzpc_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [tzpc_pkg::DIST_W-1:0] cfg_wdata,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [15:0]                 s_tdata,   // distance[15:0]
  input  logic                        s_tuser,   // zone
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [23:0]                 m_tdata,   // people_count, zone_changed,
                                                 // left_occupied, right_occupied, zero fill
  output int                          mismatches,
  output int                          pending_results,
  output int                          results_checked,
  output int                          paths_in,
  output int                          paths_out
);
  import tzpc_pkg::*;

  // doorway state as the block should hold it
  logic [DIST_W-1:0]         thresh_mm;
  logic [PAT_W-1:0]          path_log [0:3];
  logic [FILL_W-1:0]         path_len;
  logic                      left_busy;
  logic                      right_busy;
  logic signed [COUNT_W-1:0] net_people;

  result_t result_q [$];
  int      err_n;
  int      checked_n;
  int      in_n;
  int      out_n;

  // one reading through the occupancy and path logic
  task automatic count_step(input logic [DIST_W-1:0] dist_mm, input logic zone,
                            output result_t res);
    logic occ;
    logic changed;
    occ = (dist_mm < thresh_mm);
    changed = 1'b0;
    if (zone == 1'b0) begin
      if (occ != left_busy) begin
        changed = 1'b1;
        left_busy = occ;
      end
    end else begin
      if (occ != right_busy) begin
        changed = 1'b1;
        right_busy = occ;
      end
    end
    if (changed) begin
      if (path_len < FILL_FULL) path_len = path_len + 3'd1;
      if (!left_busy && !right_busy) begin
        // both zones clear: judge a full path, then start over
        if (path_len == FILL_FULL) begin
          if (path_log[1] == PAT_LEFT && path_log[2] == PAT_BOTH &&
              path_log[3] == PAT_RIGHT) begin
            in_n++;
            if (net_people != COUNT_MAX) net_people = net_people + 16'sd1;
          end else if (path_log[1] == PAT_RIGHT && path_log[2] == PAT_BOTH &&
                       path_log[3] == PAT_LEFT) begin
            out_n++;
            if (net_people != COUNT_MIN) net_people = net_people - 16'sd1;
          end
        end
        path_len = FILL_START;
      end else begin
        path_log[path_len - 1] = {right_busy, left_busy};
      end
    end
    res.people_count   = net_people;
    res.zone_changed   = changed;
    res.left_occupied  = left_busy;
    res.right_occupied = right_busy;
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      err_n++;
      $display("%0t ns: mismatch on %s, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    if (rst) begin
      thresh_mm  = THRESH_RESET;
      path_log   = '{default: '0};
      path_len   = FILL_START;
      left_busy  = 1'b0;
      right_busy = 1'b0;
      net_people = '0;
      result_q.delete();
      err_n      = 0;
      checked_n  = 0;
      in_n       = 0;
      out_n      = 0;
    end else begin
      if (cfg_we) thresh_mm = cfg_wdata;
      // output transfer against the oldest prediction
      if (m_tvalid && m_tready) begin
        checked_n++;
        if (result_q.size() == 0) begin
          err_n++;
          $display("%0t ns: mismatch, result 0x%06h with nothing expected", $time, m_tdata);
        end else begin
          want = result_q.pop_front();
          got  = m_tdata[18:0];
          check_field("people_count", int'(want.people_count), int'(got.people_count));
          check_field("zone_changed", want.zone_changed, got.zone_changed);
          check_field("left_occupied", want.left_occupied, got.left_occupied);
          check_field("right_occupied", want.right_occupied, got.right_occupied);
          check_field("zero fill", 0, m_tdata[23:19]);
        end
      end
      // input transfer: predict its result
      if (s_tvalid && s_tready) begin
        count_step(s_tdata, s_tuser, want);
        result_q.push_back(want);
      end
    end
    mismatches      <= err_n;
    pending_results <= result_q.size();
    results_checked <= checked_n;
    paths_in        <= in_n;
    paths_out       <= out_n;
  end

endmodule

[verif/testbench.sv]
// testbench top for the people counter: clock, reset, stimulus, flow control and verdict
`timescale 1ns / 1ps

module testbench;
  import tzpc_pkg::*;

  localparam logic ZONE_LEFT  = 1'b0;
  localparam logic ZONE_RIGHT = 1'b1;
  localparam int   PHASE_ITEMS = 230;

  typedef enum int {WALK_IN, WALK_OUT, WALK_SHORT, WALK_LINGER, WALK_NOISE} walk_e;
  typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_PATTERN} ready_mode_e;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  logic [DIST_W-1:0] cfg_wdata = '0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata   = '0;   // distance[15:0]
  logic              s_tuser   = 1'b0; // zone
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [23:0]       m_tdata;          // people_count, zone_changed,
                                       // left_occupied, right_occupied, zero fill

  int mismatches;
  int pending_results;
  int results_checked;
  int paths_in;
  int paths_out;

  // stimulus side bookkeeping
  logic [DIST_W-1:0] tb_thresh = THRESH_RESET;
  int  readings_sent = 0;
  int  sweep_readings = 0;
  int  burst_left = 0;
  bit  paced = 1'b1;
  bit  bulk = 1'b0;
  bit  hold_req = 1'b0;

  always #5 clk = ~clk;

  two_zone_people_counter i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  tzpc_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .mismatches      (mismatches),
    .pending_results (pending_results),
    .results_checked (results_checked),
    .paths_in        (paths_in),
    .paths_out       (paths_out)
  );

  // distance that reads as occupied under the current threshold, any distance when the threshold is 0
  function automatic logic [15:0] occ_dist();
    if (tb_thresh == 0) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, tb_thresh - 1));
  endfunction

  // distance that reads as clear
  function automatic logic [15:0] clr_dist();
    return 16'($urandom_range(tb_thresh, 65535));
  endfunction

  // one reading transfer, then, when paced and the burst is over, a new burst and maybe a gap
  task automatic send_reading(input logic [15:0] dist_mm, input logic zone);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= dist_mm;
    s_tuser  <= zone;
    do @(posedge clk); while (!s_tready);
    readings_sent++;
    if (bulk) sweep_readings++;
    if (paced) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap != 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  // one path step, now and then repeated without a change of occupancy outside the count sweep
  task automatic step(input bit occupied, input logic zone);
    send_reading(occupied ? occ_dist() : clr_dist(), zone);
    if (!bulk && $urandom_range(0, 4) == 0)
      send_reading(occupied ? occ_dist() : clr_dist(), zone);
  endtask

  // odd reading: anywhere, or close around the threshold
  task automatic noise_reading();
    int d;
    if ($urandom_range(0, 1) == 0) d = $urandom_range(0, 65535);
    else d = int'(tb_thresh) + $urandom_range(0, 4) - 2;
    if (d < 0) d = 0;
    if (d > 65535) d = 65535;
    send_reading(16'(d), 1'($urandom_range(0, 1)));
  endtask

  // someone walking through the doorway, or something less tidy
  task automatic walk(input walk_e kind);
    logic z;
    z = 1'($urandom_range(0, 1));
    if (!bulk) begin
      step(1'b0, ZONE_LEFT);
      step(1'b0, ZONE_RIGHT);
    end
    case (kind)
      WALK_IN: begin
        step(1'b1, ZONE_LEFT);  step(1'b1, ZONE_RIGHT);
        step(1'b0, ZONE_LEFT);  step(1'b0, ZONE_RIGHT);
      end
      WALK_OUT: begin
        step(1'b1, ZONE_RIGHT); step(1'b1, ZONE_LEFT);
        step(1'b0, ZONE_RIGHT); step(1'b0, ZONE_LEFT);
      end
      WALK_SHORT: begin
        step(1'b1, z); step(1'b0, z);
      end
      // hesitation in the middle keeps overwriting the last entry
      WALK_LINGER: begin
        step(1'b1, ZONE_LEFT);  step(1'b1, ZONE_RIGHT);
        step(1'b0, ZONE_LEFT);  step(1'b1, ZONE_LEFT);
        step(1'b0, ZONE_LEFT);  step(1'b0, ZONE_RIGHT);
      end
      default: begin
        repeat ($urandom_range(2, 8)) noise_reading();
      end
    endcase
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [DIST_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tb_thresh = value;
  endtask

  // random paths at the current threshold
  task automatic random_phase();
    int start;
    int pick;
    start = readings_sent;
    while (readings_sent - start < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)      walk(WALK_IN);
      else if (pick < 70) walk(WALK_OUT);
      else if (pick < 80) walk(WALK_SHORT);
      else if (pick < 88) walk(WALK_LINGER);
      else                walk(WALK_NOISE);
    end
  endtask

  // receiver flow control
  initial begin : receiver
    ready_mode_e mode;
    int span;
    int tick;
    int hold_n;
    mode = READY_ALWAYS;
    span = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (span == 0) begin
        mode = ready_mode_e'($urandom_range(0, 3));
        span = $urandom_range(50, 300);
      end else begin
        span--;
      end
      if (hold_req) begin
        // long hold-off so the block fills up and stalls its input
        hold_req = 1'b0;
        m_tready <= 1'b0;
        for (hold_n = 0; hold_n < 80; hold_n++) @(posedge clk);
      end else if (bulk) begin
        m_tready <= 1'b1;
      end else begin
        case (mode)
          READY_ALWAYS:  m_tready <= 1'b1;
          READY_HALF:    m_tready <= 1'($urandom_range(0, 1));
          READY_SPARSE:  m_tready <= ($urandom_range(0, 3) == 0);
          default:       m_tready <= (tick % 5 < 3);
        endcase
      end
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

  // stimulus and verdict
  initial begin : stimulus
    int i;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: one path each way at the reset threshold, boundaries included
    send_reading(16'd0,     ZONE_LEFT);
    send_reading(16'd500,   ZONE_RIGHT);
    send_reading(16'd65535, ZONE_LEFT);
    send_reading(16'd1000,  ZONE_RIGHT);
    send_reading(16'd999,   ZONE_RIGHT);
    send_reading(16'd0,     ZONE_LEFT);
    send_reading(16'd1001,  ZONE_RIGHT);
    send_reading(16'd2000,  ZONE_LEFT);
    // short path on the left, then on the right a reading that changes nothing and a short path with a repeat inside
    send_reading(16'd10,    ZONE_LEFT);
    send_reading(16'd65535, ZONE_LEFT);
    send_reading(16'd65535, ZONE_RIGHT);
    send_reading(16'd0,     ZONE_RIGHT);
    send_reading(16'd1,     ZONE_RIGHT);
    send_reading(16'd40000, ZONE_RIGHT);
    // full path whose last entry is overwritten into an unknown pattern
    send_reading(16'd5,     ZONE_LEFT);
    send_reading(16'd5,     ZONE_RIGHT);
    send_reading(16'd6000,  ZONE_LEFT);
    send_reading(16'd5,     ZONE_LEFT);
    send_reading(16'd6000,  ZONE_RIGHT);
    send_reading(16'd6000,  ZONE_LEFT);

    // hold-off on the receiver while inward paths keep coming
    hold_req = 1'b1;
    paced = 1'b0;
    repeat (8) walk(WALK_IN);
    paced = 1'b1;
    random_phase();

    // sender pause until all results are in, then the threshold extremes and a random value
    drain_results();
    write_threshold(16'd0);
    random_phase();
    drain_results();
    write_threshold(16'd65535);
    random_phase();
    drain_results();
    write_threshold(16'($urandom_range(1, 65534)));
    random_phase();
    drain_results();
    write_threshold(16'd1);
    random_phase();

    // full-speed sweep of the count upwards by 40 paths and then down by 80
    drain_results();
    write_threshold(16'($urandom_range(2, 65535)));
    send_reading(clr_dist(), ZONE_LEFT);
    send_reading(clr_dist(), ZONE_RIGHT);
    bulk = 1'b1;
    paced = 1'b0;
    for (i = 0; i < 40; i++) walk(WALK_IN);
    for (i = 0; i < 80; i++) walk(WALK_OUT);
    bulk = 1'b0;
    paced = 1'b1;

    drain_results();
    write_threshold(16'($urandom_range(0, 65535)));
    random_phase();

    drain_results();
    $display("run: %0d readings sent (%0d in the count sweep), %0d results checked",
             readings_sent, sweep_readings, results_checked);
    $display("paths judged: %0d inward, %0d outward; thresholds 0, 1, 1000, 65535 and random",
             paths_in, paths_out);
    if (mismatches == 0 && pending_results == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/tzpc_pkg.sv
hw/rtl/tzpc_in_stage.sv
hw/rtl/tzpc_core.sv
hw/rtl/two_zone_people_counter.sv
verif/tzpc_checker.sv
verif/testbench.sv
